FILE: rtl/rtttl_pkg.sv
// shared types and constants for the ringtone parser
`timescale 1ns / 1ps
package rtttl_pkg;
    localparam logic [1:0] KIND_NOTE = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [2:0] PH_NAME  = 3'd0;
    localparam logic [2:0] PH_SET   = 3'd1;
    localparam logic [2:0] PH_NOTES = 3'd2;

    localparam logic [17:0] WHOLE_NUM = 18'd240000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [12:0] freq_hz;
        logic [19:0] note_ms;
        logic [19:0] total_ms;
        logic        run_end;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic start_bpm;   // divide 240000 by bpm
        logic start_note;  // divide whole note by divisor
        logic finish;      // evaluate pending note, or store the whole note after a bpm division
        logic end_run;     // emit end result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic busy;
        logic done;
    } stat_t;

    function automatic logic [12:0] tone(input logic [3:0] s);
        case (s)
            4'd0:    tone = 13'd262;
            4'd1:    tone = 13'd277;
            4'd2:    tone = 13'd294;
            4'd3:    tone = 13'd311;
            4'd4:    tone = 13'd330;
            4'd5:    tone = 13'd349;
            4'd6:    tone = 13'd370;
            4'd7:    tone = 13'd392;
            4'd8:    tone = 13'd415;
            4'd9:    tone = 13'd440;
            4'd10:   tone = 13'd466;
            4'd11:   tone = 13'd494;
            default: tone = 13'd0;
        endcase
    endfunction
endpackage

FILE: rtl/rtttl_if.sv
// valid/ready channel
`timescale 1ns / 1ps
interface rtttl_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/rtttl_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rtttl_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [17:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [17:0] quotient
);
    logic [17:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [15:0] d_reg, d_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [17:0] trial;

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = q_reg;
    assign trial = {r_reg, q_reg[17]} - {2'b00, d_reg};

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = 5'd18;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[17])
            begin
                r_next = trial[16:0];
                q_next = {q_reg[16:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[15:0], q_reg[17]};
                q_next = {q_reg[16:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end
endmodule

FILE: rtl/rtttl_datapath.sv
// parse state, divider and result forming
`timescale 1ns / 1ps
module rtttl_datapath #(
    parameter int MAX_LENGTH   = 1024,
    parameter int MAX_TOTAL_MS = 600000
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [7:0]        text_byte,
    input  logic              final_byte,
    input  rtttl_pkg::cmd_t   cmd,
    output rtttl_pkg::stat_t  stat,
    output logic              want_bpm,
    output logic              want_note,
    output logic              want_finish,
    output logic              emit_note,
    output rtttl_pkg::result_t res
);
    localparam int LW = $clog2(MAX_LENGTH + 2);
    localparam logic [19:0] MAXT = 20'(MAX_TOTAL_MS);

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  sub_reg, sub_next;
    logic [15:0] acc_reg, acc_next;
    logic        have_reg, have_next;
    logic [1:0]  key_reg, key_next;
    logic [15:0] ddiv_reg, ddiv_next;
    logic [3:0]  doct_reg, doct_next;
    logic [15:0] bpm_reg, bpm_next;
    logic [17:0] whole_reg, whole_next;
    logic [15:0] ndiv_reg, ndiv_next;
    logic [3:0]  sem_reg, sem_next;
    logic        pause_reg, pause_next;
    logic        dot_reg, dot_next;
    logic        octs_reg, octs_next;
    logic [3:0]  oct_reg, oct_next;
    logic [19:0] el_reg, el_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic        any_reg, any_next;
    logic        fail_reg, fail_next;
    logic        fin_reg, fin_next;
    logic        wb, wn, wf, ok_next;
    // marks that the running division is for the whole note
    logic        whole_pending_reg, whole_pending_next;

    logic        dv_start, dv_busy, dv_done;
    logic [17:0] dv_q, dv_dend;
    logic [15:0] dv_dsor;

    rtttl_div u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_dend),
        .divisor(dv_dsor), .busy(dv_busy), .done(dv_done), .quotient(dv_q)
    );

    // the division starts on the byte that is being taken, so use its updates
    assign dv_start = cmd.start_bpm | cmd.start_note;
    assign dv_dend = cmd.start_bpm ? rtttl_pkg::WHOLE_NUM : whole_reg;
    assign dv_dsor = cmd.start_bpm ? bpm_next : (have_next ? ndiv_next : ddiv_next);
    assign stat.busy = dv_busy;
    assign stat.done = dv_done;

    function automatic logic [15:0] digit_add(input logic [15:0] a, input logic [7:0] c,
                                              output logic ovf);
        logic [19:0] t;
        t = {a, 3'b000} + {3'd0, a, 1'b0} + {16'd0, c[3:0]};
        ovf = (t > 20'd65535);
        digit_add = t[15:0];
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        is_dig = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        is_sep = (c == 8'h2c) || (c == 8'h20);
    endfunction

    // note duration and freq from division result
    logic [19:0] dur_b, dur;
    logic [3:0]  o_eff, s_eff;
    logic [4:0]  o_adj;
    logic [12:0] tv, fq;
    logic        note_bad;
    always_comb
    begin
        dur_b = {2'b00, dv_q};
        dur = dot_reg ? 20'((21'(dur_b) * 21'd3) >> 1) : dur_b;
        o_eff = octs_reg ? oct_reg : doct_reg;
        s_eff = sem_reg;
        o_adj = {1'b0, o_eff};
        if (sem_reg >= 4'd12)
        begin
            s_eff = sem_reg - 4'd12;
            o_adj = o_adj + 5'd1;
        end
        tv = rtttl_pkg::tone(s_eff);
        if (o_adj >= 5'd4)
            fq = 13'(tv << (o_adj - 5'd4));
        else
            fq = tv >> (5'd4 - o_adj);
        note_bad = (dur == 20'd0) || (el_reg > MAXT) || (dur > MAXT - el_reg);
        if (!pause_reg && (o_adj > 5'd8 || s_eff >= 4'd12))
            note_bad = 1'b1;
        if (pause_reg)
            fq = '0;
    end

    always_comb
    begin
        logic [7:0]  c;
        logic [15:0] na;
        logic        ov, letter_ok, do_letter, do_mod, end_set;
        logic [3:0]  lsem;
        logic        lp;
        logic [7:0]  lc;
        phase_next = phase_reg; sub_next = sub_reg; acc_next = acc_reg;
        have_next = have_reg; key_next = key_reg; ddiv_next = ddiv_reg;
        doct_next = doct_reg; bpm_next = bpm_reg; whole_next = whole_reg;
        ndiv_next = ndiv_reg; sem_next = sem_reg; pause_next = pause_reg;
        dot_next = dot_reg; octs_next = octs_reg; oct_next = oct_reg;
        el_next = el_reg; cnt_next = cnt_reg; any_next = any_reg;
        fail_next = fail_reg; fin_next = fin_reg;
        wb = 1'b0; wn = 1'b0; wf = 1'b0; ok_next = 1'b0;
        emit_note = 1'b0;
        res = '0;
        c = text_byte;
        na = '0; ov = 1'b0; do_letter = 1'b0; do_mod = 1'b0; end_set = 1'b0;
        letter_ok = 1'b1; lsem = '0; lp = 1'b0;
        lc = (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
        case (lc)
            8'h63: lsem = 4'd0;
            8'h64: lsem = 4'd2;
            8'h65: lsem = 4'd4;
            8'h66: lsem = 4'd5;
            8'h67: lsem = 4'd7;
            8'h61: lsem = 4'd9;
            8'h62: lsem = 4'd11;
            8'h70: lp = 1'b1;
            default: letter_ok = 1'b0;
        endcase
        if (load)
        begin
            fin_next = final_byte;
            if (!fail_reg)
            begin
                if (cnt_reg <= LW'(MAX_LENGTH))
                    cnt_next = cnt_reg + LW'(1);
                if (cnt_next > LW'(MAX_LENGTH) || c == 8'h00)
                    fail_next = 1'b1;
                else if (phase_reg == rtttl_pkg::PH_NAME)
                begin
                    if (c == 8'h3a)
                    begin
                        phase_next = rtttl_pkg::PH_SET;
                        sub_next = 3'd0;
                    end
                end
                else if (phase_reg == rtttl_pkg::PH_SET)
                begin
                    case (sub_reg)
                        3'd0:
                        begin
                            if (c == 8'h3a)
                                wb = 1'b1;
                            else if (!is_sep(c))
                            begin
                                key_next = (c == 8'h64) ? 2'd0 : (c == 8'h6f) ? 2'd1 :
                                           (c == 8'h62) ? 2'd2 : 2'd3;
                                sub_next = 3'd1;
                            end
                        end
                        3'd1, 3'd2:
                        begin
                            if (c == 8'h3d && sub_reg == 3'd1)
                                sub_next = 3'd2;
                            else if (is_dig(c))
                            begin
                                acc_next = digit_add(16'd0, c, ov);
                                sub_next = 3'd3;
                            end
                            else
                                fail_next = 1'b1;
                        end
                        default:
                        begin
                            if (is_dig(c))
                            begin
                                na = digit_add(acc_reg, c, ov);
                                if (ov)
                                    fail_next = 1'b1;
                                else
                                    acc_next = na;
                            end
                            else
                                end_set = 1'b1;
                        end
                    endcase
                    if (end_set)
                    begin
                        if (key_reg == 2'd0 && acc_reg != 16'd0)
                            ddiv_next = acc_reg;
                        else if (key_reg == 2'd1 && acc_reg <= 16'd8)
                            doct_next = acc_reg[3:0];
                        else if (key_reg == 2'd2 && acc_reg != 16'd0)
                            bpm_next = acc_reg;
                        else
                            fail_next = 1'b1;
                        if (!fail_next)
                        begin
                            acc_next = '0;
                            if (c == 8'h3a)
                                wb = 1'b1;
                            else if (is_sep(c))
                                sub_next = 3'd0;
                            else
                                fail_next = 1'b1;
                        end
                    end
                    if (wb)
                    begin
                        phase_next = rtttl_pkg::PH_NOTES;
                        sub_next = 3'd0;
                        have_next = 1'b0; ndiv_next = '0; sem_next = '0;
                        pause_next = 1'b0; dot_next = 1'b0; octs_next = 1'b0;
                        oct_next = '0; acc_next = '0;
                    end
                end
                else
                begin
                    case (sub_reg)
                        3'd0:
                        begin
                            if (is_dig(c))
                            begin
                                acc_next = digit_add(16'd0, c, ov);
                                sub_next = 3'd1;
                            end
                            else if (!is_sep(c))
                                do_letter = 1'b1;
                        end
                        3'd1:
                        begin
                            if (is_dig(c))
                            begin
                                na = digit_add(acc_reg, c, ov);
                                if (ov)
                                    fail_next = 1'b1;
                                else
                                    acc_next = na;
                            end
                            else if (acc_reg == 16'd0)
                                fail_next = 1'b1;
                            else
                            begin
                                ndiv_next = acc_reg;
                                have_next = 1'b1;
                                acc_next = '0;
                                do_letter = 1'b1;
                            end
                        end
                        3'd2:
                        begin
                            if (c == 8'h23)
                            begin
                                if (pause_reg)
                                    fail_next = 1'b1;
                                else
                                begin
                                    sem_next = sem_reg + 4'd1;
                                    sub_next = 3'd3;
                                end
                            end
                            else
                                do_mod = 1'b1;
                        end
                        3'd4:
                        begin
                            if (is_dig(c))
                            begin
                                na = digit_add(acc_reg, c, ov);
                                if (ov)
                                    fail_next = 1'b1;
                                else
                                begin
                                    acc_next = na;
                                    if (na > 16'd8)
                                        fail_next = 1'b1;
                                end
                            end
                            else
                            begin
                                oct_next = acc_reg[3:0];
                                octs_next = 1'b1;
                                acc_next = '0;
                                do_mod = 1'b1;
                            end
                        end
                        default: do_mod = 1'b1;
                    endcase
                    if (do_letter)
                    begin
                        if (letter_ok)
                        begin
                            if (lp)
                                pause_next = 1'b1;
                            else
                                sem_next = lsem;
                            sub_next = 3'd2;
                        end
                        else
                            fail_next = 1'b1;
                    end
                    if (do_mod)
                    begin
                        sub_next = 3'd3;
                        if (c == 8'h2e)
                        begin
                            if (dot_reg)
                                fail_next = 1'b1;
                            else
                                dot_next = 1'b1;
                        end
                        else if (is_dig(c))
                        begin
                            if (octs_next)
                                fail_next = 1'b1;
                            else
                            begin
                                acc_next = digit_add(16'd0, c, ov);
                                if (acc_next > 16'd8)
                                    fail_next = 1'b1;
                                sub_next = 3'd4;
                            end
                        end
                        else if (is_sep(c))
                            wn = 1'b1;
                        else
                            fail_next = 1'b1;
                    end
                end
            end
            // end of text with a note pending
            if (final_byte && !fail_next && !wn && phase_next == rtttl_pkg::PH_NOTES &&
                sub_next != 3'd0 && sub_next != 3'd1)
            begin
                wn = 1'b1;
                if (sub_next == 3'd4)
                begin
                    oct_next = acc_next[3:0];
                    octs_next = 1'b1;
                end
            end
            wf = final_byte & ~wn;
        end
        if (cmd.finish)
        begin
            // whole note ready when phase entry was a bpm division
            if (!fail_reg && whole_pending_reg)
                whole_next = dv_q;
            else if (!fail_reg)
            begin
                if (note_bad)
                    fail_next = 1'b1;
                else
                begin
                    emit_note = 1'b1;
                    res.kind = rtttl_pkg::KIND_NOTE;
                    res.freq_hz = fq;
                    res.note_ms = dur;
                    res.run_end = ~fin_reg;
                    el_next = el_reg + dur;
                    any_next = 1'b1;
                    have_next = 1'b0; ndiv_next = '0; sem_next = '0;
                    pause_next = 1'b0; dot_next = 1'b0; octs_next = 1'b0;
                    oct_next = '0; acc_next = '0; sub_next = 3'd0;
                end
            end
        end
        if (cmd.end_run)
        begin
            // a pending note has been closed by now, so only a clean note boundary passes
            ok_next = !fail_reg && phase_reg == rtttl_pkg::PH_NOTES &&
                      sub_reg == 3'd0 && any_reg;
            res.kind = ok_next ? rtttl_pkg::KIND_OK : rtttl_pkg::KIND_ERR;
            res.freq_hz = '0;
            res.note_ms = '0;
            res.total_ms = ok_next ? el_reg : 20'd0;
            res.run_end = 1'b1;
            phase_next = rtttl_pkg::PH_NAME; sub_next = '0; acc_next = '0;
            have_next = 1'b0; key_next = '0; ddiv_next = 16'd4; doct_next = 4'd6;
            bpm_next = 16'd63; whole_next = '0; ndiv_next = '0; sem_next = '0;
            pause_next = 1'b0; dot_next = 1'b0; octs_next = 1'b0; oct_next = '0;
            el_next = '0; cnt_next = '0; any_next = 1'b0; fail_next = 1'b0;
            fin_next = 1'b0;
        end
    end

    always_comb
    begin
        whole_pending_next = whole_pending_reg;
        if (cmd.start_bpm)
            whole_pending_next = 1'b1;
        else if (cmd.start_note || cmd.end_run)
            whole_pending_next = 1'b0;
    end

    assign want_bpm = wb;
    assign want_note = wn;
    assign want_finish = wf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rtttl_pkg::PH_NAME; sub_reg <= '0; acc_reg <= '0;
            have_reg <= 1'b0; key_reg <= '0; ddiv_reg <= 16'd4; doct_reg <= 4'd6;
            bpm_reg <= 16'd63; whole_reg <= '0; ndiv_reg <= '0; sem_reg <= '0;
            pause_reg <= 1'b0; dot_reg <= 1'b0; octs_reg <= 1'b0; oct_reg <= '0;
            el_reg <= '0; cnt_reg <= '0; any_reg <= 1'b0; fail_reg <= 1'b0;
            fin_reg <= 1'b0; whole_pending_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; sub_reg <= sub_next; acc_reg <= acc_next;
            have_reg <= have_next; key_reg <= key_next; ddiv_reg <= ddiv_next;
            doct_reg <= doct_next; bpm_reg <= bpm_next; whole_reg <= whole_next;
            ndiv_reg <= ndiv_next; sem_reg <= sem_next; pause_reg <= pause_next;
            dot_reg <= dot_next; octs_reg <= octs_next; oct_reg <= oct_next;
            el_reg <= el_next; cnt_reg <= cnt_next; any_reg <= any_next;
            fail_reg <= fail_next; fin_reg <= fin_next;
            whole_pending_reg <= whole_pending_next;
        end
    end
endmodule

FILE: rtl/rtttl_ctrl.sv
// sequencer for byte intake, divisions and result hand-off
`timescale 1ns / 1ps
module rtttl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             load,
    input  logic             final_byte,
    input  logic             want_bpm,
    input  logic             want_note,
    input  logic             want_finish,
    input  logic             emit_note,
    input  rtttl_pkg::stat_t stat,
    output rtttl_pkg::cmd_t  cmd,
    output logic             out_load,
    input  logic             out_free
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_BPM   = 6'b000010,
        S_NOTE  = 6'b000100,
        S_NWAIT = 6'b001000,
        S_END   = 6'b010000,
        S_EWAIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   fin_reg, fin_next;

    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign load = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        fin_next = fin_reg;
        cmd = '0;
        out_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (load)
                begin
                    fin_next = final_byte;
                    if (want_bpm)
                    begin
                        cmd.start_bpm = 1'b1;
                        state_next = S_BPM;
                    end
                    else if (want_note)
                    begin
                        cmd.start_note = 1'b1;
                        state_next = S_NOTE;
                    end
                    else if (want_finish)
                        state_next = S_END;
                end
            end
            S_BPM:
            begin
                if (stat.done)
                begin
                    cmd.finish = 1'b1;
                    state_next = fin_reg ? S_END : S_IDLE;
                end
            end
            S_NOTE:
            begin
                if (stat.done)
                    state_next = S_NWAIT;
            end
            S_NWAIT:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    out_load = emit_note;
                    state_next = fin_reg ? S_END : S_IDLE;
                end
            end
            S_END:
            begin
                if (out_free)
                begin
                    cmd.end_run = 1'b1;
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EWAIT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg <= fin_next;
        end
    end
endmodule

FILE: rtl/rtttl_ringtone_parser_core.sv
// ringtone parser top level: controller, datapath and output register
// an end byte goes to S_END, which loads the end result; a byte that closes a note starts a
// division, S_NOTE waits for its done and S_NWAIT loads the note; ':' closing the settings
// waits in S_BPM on the 18-step divider; no new byte is taken outside S_IDLE or while the
// output is full, so stalls hold input; reset: rst_n async active low, back to name section
`timescale 1ns / 1ps
module rtttl_ringtone_parser_core #(
    parameter int MAX_LENGTH   = 1024,
    parameter int MAX_TOTAL_MS = 600000
) (
    input logic clk,
    input logic rst_n,
    rtttl_if.sink   in_ch,
    rtttl_if.source out_ch
);
    rtttl_pkg::cmd_t    cmd;
    rtttl_pkg::stat_t   stat;
    rtttl_pkg::result_t res;
    logic load, out_load, want_bpm, want_note, want_finish, emit_note;
    logic out_valid_reg;
    rtttl_pkg::result_t out_reg;
    logic out_free;

    assign out_free = !out_valid_reg || out_ch.ready;

    rtttl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .load(load), .final_byte(in_ch.data[8]), .want_bpm(want_bpm),
        .want_note(want_note), .want_finish(want_finish), .emit_note(emit_note),
        .stat(stat), .cmd(cmd), .out_load(out_load), .out_free(out_free)
    );

    rtttl_datapath #(.MAX_LENGTH(MAX_LENGTH), .MAX_TOTAL_MS(MAX_TOTAL_MS)) u_dp (
        .clk(clk), .rst_n(rst_n), .load(load), .text_byte(in_ch.data[7:0]),
        .final_byte(in_ch.data[8]), .cmd(cmd), .stat(stat), .want_bpm(want_bpm),
        .want_note(want_note), .want_finish(want_finish),
        .emit_note(emit_note), .res(res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= res;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_reg;
endmodule
